// ----- hw/rtl/pcbd_pkg.sv -----
// pcbd_pkg: types, constants and range table for the pulse-count backlight dimmer
// used by pcbd_map, pcbd_track and pulse_count_backlight_dimmer
`timescale 1ns / 1ps

package pcbd_pkg;

    // dimming chip steps, a power of two so the pulse count wraps on its low bits
    localparam int STEP_COUNT    = 32;
    localparam int STEP_W        = $clog2(STEP_COUNT);
    localparam int TABLE_ENTRIES = 21;
    localparam int RANGE_ROWS    = 21;
    localparam int LEVEL_W       = 8;
    localparam int NEW_STEP_W    = 6;
    localparam int PULSE_W       = 5;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // percent rescale: level * 255 / 100, floor, by reciprocal 5243 / 2^19
    localparam logic [7:0]  LEVEL_MAX = 8'd255;
    localparam logic [7:0]  PCT_FULL  = 8'd100;
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    localparam int          PCT_SHIFT = 19;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMMING_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_INPUT = 2'd2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] MIN_LEVEL_RST    = 8'd30;
    localparam logic [4:0] DIMMING_STEP_RST = 5'd31;

    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [NEW_STEP_W-1:0] step_t;

    typedef struct packed {
        step_t              new_step;
        logic [PULSE_W-1:0] pulse_count;
        logic               enable_first;
        logic               reset_low_first;
        logic               drive_off;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    localparam level_t RANGE_TOP [RANGE_ROWS] = '{
        8'd255, 8'd244, 8'd233, 8'd222, 8'd211, 8'd200, 8'd189, 8'd178, 8'd166,
        8'd154, 8'd141, 8'd127, 8'd113, 8'd99,  8'd85,  8'd71,  8'd57,  8'd43,
        8'd30,  8'd20,  8'd0
    };

    localparam step_t RANGE_STEP [RANGE_ROWS] = '{
        6'd7,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd16, 6'd18, 6'd20,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd31, 6'd31,
        6'd32
    };

endpackage

// ----- hw/rtl/pcbd_map.sv -----
// pcbd_map: turns a brightness request into a target step
// optional percent rescale, dimming threshold and range table; uses pcbd_pkg
`timescale 1ns / 1ps

module pcbd_map (
    input  pcbd_pkg::level_t level,
    input  logic             percent_input,
    input  pcbd_pkg::level_t min_level,
    input  logic [4:0]       dimming_step,
    output pcbd_pkg::step_t  target
);
    import pcbd_pkg::*;

    logic [15:0] scaled_full;
    logic [28:0] recip_prod;
    level_t      pct_level;
    level_t      lvl;

    // level * 255 as a shift and subtract
    assign scaled_full = {level, 8'd0} - {8'd0, level};
    assign recip_prod  = {13'd0, scaled_full} * {16'd0, PCT_RECIP};
    assign pct_level   = (level > PCT_FULL) ? LEVEL_MAX
                                            : recip_prod[PCT_SHIFT +: LEVEL_W];
    assign lvl         = percent_input ? pct_level : level;

    always_comb begin
        logic found;
        found  = 1'b0;
        target = '0;
        if (lvl == '0) begin
            target = '0;
        end else if (lvl < min_level) begin
            target = {1'b0, dimming_step};
        end else begin
            for (int i = 0; i < TABLE_ENTRIES - 1 && i < RANGE_ROWS - 1; i++) begin
                if (!found && lvl <= RANGE_TOP[i] && lvl > RANGE_TOP[i+1]) begin
                    target = RANGE_STEP[i];
                    found  = 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/pcbd_track.sv -----
// pcbd_track: holds the chip's current step and works out line actions and pulses
// updates its state when an item moves on; uses pcbd_pkg
`timescale 1ns / 1ps

module pcbd_track (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  pcbd_pkg::step_t   target,
    input  logic              line_is_high,
    output pcbd_pkg::result_t result
);
    import pcbd_pkg::*;

    step_t current_step_reg, current_step_next;
    logic  step_known_reg, step_known_next;

    always_comb begin
        step_t cur;
        step_t diff;
        cur    = '0;
        diff   = '0;
        result = '0;
        result.new_step = target;
        if (target == '0) begin
            result.drive_off = 1'b1;
        end else begin
            if (!step_known_reg) begin
                if (line_is_high) begin
                    result.reset_low_first = 1'b1;
                    cur = '0;
                end else begin
                    // unknown with line low counts as one below zero
                    cur = NEW_STEP_W'(STEP_COUNT - 1);
                end
            end else begin
                cur = current_step_reg;
            end
            if ((step_known_reg || line_is_high) && cur == '0) begin
                result.enable_first = 1'b1;
                cur = NEW_STEP_W'(STEP_COUNT);
            end
            diff = target - cur;
            result.pulse_count = PULSE_W'(diff[STEP_W-1:0]);
        end
    end

    assign current_step_next = advance ? target : current_step_reg;
    assign step_known_next   = advance ? 1'b1 : step_known_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_step_reg <= '0;
            step_known_reg   <= 1'b0;
        end else begin
            current_step_reg <= current_step_next;
            step_known_reg   <= step_known_next;
        end
    end

endmodule

// ----- hw/rtl/pulse_count_backlight_dimmer.sv -----
// Backlight dimmer for a one-wire, 32-step pulse-count dimming chip. Each input
// item is a brightness request; each produces exactly one result item telling
// whether to hold the line low, reset it low first, raise it to enable, how many
// pulses to send and the step the chip holds afterwards. One item per clock is
// accepted while m_tready does not hold the output back; each item passes the input
// register, then the result register, and while a result waits an empty input
// register still lets the next item in. Configuration writes must happen while no
// item is in flight.
// depends on pcbd_pkg, pcbd_map, pcbd_track
`timescale 1ns / 1ps

module pulse_count_backlight_dimmer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] level, [8] line_is_high, rest zero
    input  logic [pcbd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] drive_off, [1] reset_low_first, [2] enable_first, [7:3] pulse_count,
    // [13:8] new_step, rest zero
    output logic [pcbd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [pcbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcbd_pkg::*;

    level_t     min_level_reg;
    logic [4:0] dimming_step_reg;
    logic       percent_input_reg;

    logic    in_valid_reg, in_valid_next;
    level_t  in_level_reg;
    logic    in_line_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic    advance;
    step_t   target;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg     <= MIN_LEVEL_RST;
            dimming_step_reg  <= DIMMING_STEP_RST;
            percent_input_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_LEVEL:     min_level_reg     <= cfg_data[7:0];
                CFG_DIMMING_STEP:  dimming_step_reg  <= cfg_data[4:0];
                CFG_PERCENT_INPUT: percent_input_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // an item moves from the input register once the result register is free
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[7:0];
            in_line_reg  <= s_tdata[8];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    pcbd_map u_map (
        .level         (in_level_reg),
        .percent_input (percent_input_reg),
        .min_level     (min_level_reg),
        .dimming_step  (dimming_step_reg),
        .target        (target)
    );

    pcbd_track u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .target       (target),
        .line_is_high (in_line_reg),
        .result       (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_data_reg};

endmodule
